// File: rtl/dtu_pkg.sv
package dtu_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int MOISTURE_BITS = 16;
  localparam int VEL_W = 32;
  localparam int SQ_W = 66;             // sum of three squares
  localparam int SPEED_W = 33;          // floor sqrt of sum
  localparam int PROD_W = 64;           // |vi*vj|
  localparam int OUT_W = 48;
  localparam int DIV_STEPS = 4;         // quotient bits per divider stage
  localparam int SQRT_STEPS = 3;        // result bits per root stage
  localparam int NUM_ENT = 6;

  localparam logic [1:0] REG_MOLECULAR = 2'd0;
  localparam logic [1:0] REG_LONGITUDINAL = 2'd1;
  localparam logic [1:0] REG_TRANSVERSE = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  localparam logic signed [63:0] CLAMP = 64'sd1 <<< 60;

  typedef struct packed {
    logic [30:0]        molecular;
    logic signed [31:0] longitudinal;
    logic signed [31:0] transverse;
    logic [15:0]        threshold;
  } cfg_t;

  // round half away from zero of a*b/2^s, clamped to 2^60 magnitude
  // a and b are magnitudes up to 64 bits; neg gives the sign
  function automatic logic signed [63:0] round_clamp(input logic [127:0] prod,
                                                       input logic neg,
                                                       input int s);
    logic [127:0] r;
    logic [63:0]  v;
    r = (prod + (128'd1 << (s - 1))) >> s;
    v = (r > 128'(CLAMP)) ? 64'(CLAMP) : r[63:0];
    return neg ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat48(input logic signed [65:0] v);
    if (v > 66'sh7FFFFFFFFFFF) return {1'b0, {(OUT_W-1){1'b1}}};
    if (v < -66'sh800000000000) return {1'b1, {(OUT_W-1){1'b0}}};
    return v[OUT_W-1:0];
  endfunction

endpackage

// File: rtl/dtu_sqrt.sv
// pipelined restoring square root, a few result bits per stage
module dtu_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [dtu_pkg::SQ_W-1:0]    in_sum,
  output logic                        out_valid,
  output logic [dtu_pkg::SPEED_W-1:0] out_root
);
  localparam int NST = (dtu_pkg::SPEED_W + dtu_pkg::SQRT_STEPS - 1) / dtu_pkg::SQRT_STEPS;
  localparam int RW = dtu_pkg::SQ_W + 2;

  logic                        v_r   [NST+1];
  logic [RW-1:0]               rem_r [NST+1];
  logic [dtu_pkg::SPEED_W-1:0] root_r[NST+1];
  logic [dtu_pkg::SQ_W-1:0]    x_r   [NST+1];

  always_comb begin
    v_r[0] = in_valid;
    rem_r[0] = '0;
    root_r[0] = '0;
    x_r[0] = in_sum;
  end

  for (genvar g = 0; g < NST; g++) begin : g_st
    logic [RW-1:0]               rem_nxt;
    logic [dtu_pkg::SPEED_W-1:0] root_nxt;
    logic [dtu_pkg::SQ_W-1:0]    x_nxt;
    always_comb begin
      logic [RW-1:0] trial;
      rem_nxt = rem_r[g];
      root_nxt = root_r[g];
      x_nxt = x_r[g];
      for (int k = 0; k < dtu_pkg::SQRT_STEPS; k++) begin
        if (g * dtu_pkg::SQRT_STEPS + k < dtu_pkg::SPEED_W) begin
          rem_nxt = {rem_nxt[RW-3:0], x_nxt[dtu_pkg::SQ_W-1 -: 2]};
          x_nxt = x_nxt << 2;
          trial = {root_nxt, 2'b01};
          if (rem_nxt >= trial) begin
            rem_nxt = rem_nxt - trial;
            root_nxt = {root_nxt[dtu_pkg::SPEED_W-2:0], 1'b1};
          end else begin
            root_nxt = {root_nxt[dtu_pkg::SPEED_W-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[g+1] <= 1'b0;
      else v_r[g+1] <= v_r[g];
      rem_r[g+1] <= rem_nxt;
      root_r[g+1] <= root_nxt;
      x_r[g+1] <= x_nxt;
    end
  end

  assign out_valid = v_r[NST];
  assign out_root = root_r[NST];
endmodule

// File: rtl/dtu_div.sv
// pipelined restoring divider, magnitude by speed, a few quotient bits per stage
module dtu_div (
  input  logic                        clk,
  input  logic [dtu_pkg::PROD_W-1:0]  in_num,
  input  logic [dtu_pkg::SPEED_W-1:0] in_den,
  output logic [dtu_pkg::PROD_W-1:0]  out_quot
);
  localparam int NST = dtu_pkg::PROD_W / dtu_pkg::DIV_STEPS;
  localparam int RW = dtu_pkg::SPEED_W + 1;

  logic [RW-1:0]                rem_r[NST+1];
  logic [dtu_pkg::PROD_W-1:0]   q_r  [NST+1];
  logic [dtu_pkg::SPEED_W-1:0]  d_r  [NST+1];

  always_comb begin
    rem_r[0] = '0;
    q_r[0] = in_num;
    d_r[0] = in_den;
  end

  for (genvar g = 0; g < NST; g++) begin : g_st
    logic [RW-1:0]              rem_nxt;
    logic [dtu_pkg::PROD_W-1:0] q_nxt;
    always_comb begin
      rem_nxt = rem_r[g];
      q_nxt = q_r[g];
      for (int k = 0; k < dtu_pkg::DIV_STEPS; k++) begin
        rem_nxt = {rem_nxt[RW-2:0], q_nxt[dtu_pkg::PROD_W-1]};
        q_nxt = q_nxt << 1;
        if (rem_nxt >= {1'b0, d_r[g]}) begin
          rem_nxt = rem_nxt - {1'b0, d_r[g]};
          q_nxt[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      rem_r[g+1] <= rem_nxt;
      q_r[g+1] <= q_nxt;
      d_r[g+1] <= d_r[g];
    end
  end

  assign out_quot = q_r[NST];
endmodule

// File: rtl/dispersion_tensor_unit.sv
// channel | ports                                   | beat
// in      | start, busy, in_velocity_*, in_moisture | start & !busy
// out     | out_valid, out_tensor_*                 | out_valid, one cycle
// cfg     | cfg_we, cfg_index, cfg_data             | cfg_we
// one cell per clock; the path runs through the root pipeline (11 stages), the
// divider pipeline (16 stages) and four stages of products and sums.
// busy stays low: nothing downstream can stall. reset clears the valid chain
// and loads the register defaults.
module dispersion_tensor_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_velocity_x,
  input  logic signed [31:0]  in_velocity_y,
  input  logic signed [31:0]  in_velocity_z,
  input  logic [16:0]         in_moisture,
  output logic                out_valid,
  output logic signed [47:0]  out_tensor_xx,
  output logic signed [47:0]  out_tensor_yy,
  output logic signed [47:0]  out_tensor_zz,
  output logic signed [47:0]  out_tensor_xy,
  output logic signed [47:0]  out_tensor_xz,
  output logic signed [47:0]  out_tensor_yz,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  localparam int F = dtu_pkg::FRACTION_BITS;
  localparam int SQD = (dtu_pkg::SPEED_W + dtu_pkg::SQRT_STEPS - 1) / dtu_pkg::SQRT_STEPS;
  localparam int DVD = dtu_pkg::PROD_W / dtu_pkg::DIV_STEPS;

  dtu_pkg::cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{molecular: '0, longitudinal: '0, transverse: '0, threshold: 16'd1};
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtu_pkg::REG_MOLECULAR:    cfg_r.molecular <= cfg_data[30:0];
        dtu_pkg::REG_LONGITUDINAL: cfg_r.longitudinal <= cfg_data;
        dtu_pkg::REG_TRANSVERSE:   cfg_r.transverse <= cfg_data;
        dtu_pkg::REG_THRESHOLD:    cfg_r.threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  wire in_fire = start & ~busy;

  // stage 1: squares and pair products
  logic                     s1_v_r;
  logic [63:0]              sq_r [3];
  logic signed [63:0]       pp_r [dtu_pkg::NUM_ENT];
  logic [16:0]              s1_m_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= in_fire;
    sq_r[0] <= 64'(in_velocity_x * in_velocity_x);
    sq_r[1] <= 64'(in_velocity_y * in_velocity_y);
    sq_r[2] <= 64'(in_velocity_z * in_velocity_z);
    pp_r[0] <= 64'(64'(in_velocity_x) * 64'(in_velocity_x));
    pp_r[1] <= 64'(64'(in_velocity_y) * 64'(in_velocity_y));
    pp_r[2] <= 64'(64'(in_velocity_z) * 64'(in_velocity_z));
    pp_r[3] <= 64'(64'(in_velocity_x) * 64'(in_velocity_y));
    pp_r[4] <= 64'(64'(in_velocity_x) * 64'(in_velocity_z));
    pp_r[5] <= 64'(64'(in_velocity_y) * 64'(in_velocity_z));
    s1_m_r <= in_moisture;
  end

  // stage 2: sum of squares
  logic                     s2_v_r;
  logic [dtu_pkg::SQ_W-1:0] sum_r;
  logic signed [63:0]       p2_r [dtu_pkg::NUM_ENT];
  logic [16:0]              s2_m_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else s2_v_r <= s1_v_r;
    sum_r <= 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]);
    p2_r <= pp_r;
    s2_m_r <= s1_m_r;
  end

  logic                        sq_v;
  logic [dtu_pkg::SPEED_W-1:0] speed;
  dtu_sqrt u_sqrt (.clk, .rst_n, .in_valid(s2_v_r), .in_sum(sum_r),
                   .out_valid(sq_v), .out_root(speed));

  // delay products and moisture alongside the root
  logic signed [63:0] pd_r [SQD+1][dtu_pkg::NUM_ENT];
  logic [16:0]        md_r [SQD+1];
  always_comb begin
    pd_r[0] = p2_r;
    md_r[0] = s2_m_r;
  end
  for (genvar g = 0; g < SQD; g++) begin : g_pd
    always_ff @(posedge clk) begin
      pd_r[g+1] <= pd_r[g];
      md_r[g+1] <= md_r[g];
    end
  end

  // stage after root: magnitudes into dividers, base products
  logic [dtu_pkg::PROD_W-1:0] num [dtu_pkg::NUM_ENT];
  logic [dtu_pkg::PROD_W-1:0] quot[dtu_pkg::NUM_ENT];
  logic [dtu_pkg::SPEED_W-1:0] den;
  assign den = (speed == '0) ? dtu_pkg::SPEED_W'(1) : speed;
  for (genvar e = 0; e < dtu_pkg::NUM_ENT; e++) begin : g_div
    assign num[e] = pd_r[SQD][e][63] ? 64'(-pd_r[SQD][e]) : pd_r[SQD][e];
    dtu_div u_div (.clk, .in_num(num[e]), .in_den(den), .out_quot(quot[e]));
  end

  logic [DVD-2:0]             dv_v_r;
  logic [DVD-2:0]             dv_act_r;
  logic [dtu_pkg::NUM_ENT-1:0] dv_neg_r [DVD-1];
  logic signed [63:0]         dv_base_r [DVD-1];
  logic [dtu_pkg::SPEED_W-1:0] sp_r;
  logic                       b_v_r;
  logic [63:0]                bm_r, bt_r;
  logic                       bt_neg_r;

  // base computed in two registered steps, then delayed with the divide
  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else b_v_r <= sq_v;
    sp_r <= speed;
    bm_r <= 64'(cfg_r.molecular * md_r[SQD]);
    bt_r <= 64'(speed * 33'(cfg_r.transverse[31] ? -cfg_r.transverse : cfg_r.transverse));
    bt_neg_r <= cfg_r.transverse[31] && speed != '0;
  end

  logic signed [63:0] base_nxt;
  assign base_nxt = dtu_pkg::round_clamp(128'(bm_r), 1'b0, dtu_pkg::MOISTURE_BITS)
                  + dtu_pkg::round_clamp(128'(bt_r), bt_neg_r, F);

  always_comb begin
    dv_v_r[0] = b_v_r;
    dv_act_r[0] = sp_r > 33'(cfg_r.threshold);
    dv_base_r[0] = base_nxt;
  end
  logic [dtu_pkg::NUM_ENT-1:0] neg0_r;
  always_ff @(posedge clk) begin
    for (int e = 0; e < dtu_pkg::NUM_ENT; e++) neg0_r[e] <= pd_r[SQD][e][63];
  end
  assign dv_neg_r[0] = neg0_r;
  for (genvar g = 0; g < DVD - 2; g++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[g+1] <= 1'b0;
      else dv_v_r[g+1] <= dv_v_r[g];
      dv_act_r[g+1] <= dv_act_r[g];
      dv_neg_r[g+1] <= dv_neg_r[g];
      dv_base_r[g+1] <= dv_base_r[g];
    end
  end

  // base chain starts one stage after the divider; last register lines it up
  logic                        a_v_r, a_act_r;
  logic [dtu_pkg::NUM_ENT-1:0] a_neg_r;
  logic signed [63:0]          a_base_r;
  logic [63:0]                 dm_r;
  logic                        dn_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else a_v_r <= dv_v_r[DVD-2];
    a_act_r <= dv_act_r[DVD-2];
    a_neg_r <= dv_neg_r[DVD-2];
    a_base_r <= dv_base_r[DVD-2];
  end

  // dispersive products: diff (33 bit) times quotient (64 bit), split
  logic signed [32:0] diff;
  assign diff = 33'(cfg_r.longitudinal) - 33'(cfg_r.transverse);
  always_comb begin
    dm_r = diff[32] ? 64'(-diff) : 64'(diff);
    dn_r = diff[32];
  end

  logic         m_v_r, m_act_r;
  logic [63:0]  plo_r[dtu_pkg::NUM_ENT], phi_r[dtu_pkg::NUM_ENT];
  logic [dtu_pkg::NUM_ENT-1:0] m_neg_r;
  logic signed [63:0] m_base_r;
  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else m_v_r <= a_v_r;
    m_act_r <= a_act_r;
    m_base_r <= a_base_r;
    for (int e = 0; e < dtu_pkg::NUM_ENT; e++) begin
      plo_r[e] <= dm_r * 64'(quot[e][31:0]);
      phi_r[e] <= dm_r * 64'(quot[e][63:32]);
      m_neg_r[e] <= (a_neg_r[e] ^ dn_r) && quot[e] != '0 && dm_r != '0;
    end
  end

  logic signed [47:0] res_nxt [dtu_pkg::NUM_ENT];
  always_comb begin
    logic signed [63:0] disp;
    for (int e = 0; e < dtu_pkg::NUM_ENT; e++) begin
      disp = m_act_r ? dtu_pkg::round_clamp(128'(plo_r[e]) + (128'(phi_r[e]) << 32),
                                            m_neg_r[e], F) : 64'sd0;
      res_nxt[e] = (e < 3) ? dtu_pkg::sat48(66'(m_base_r) + 66'(disp))
                           : dtu_pkg::sat48(66'(disp));
    end
  end

  logic               o_v_r;
  logic signed [47:0] o_r[dtu_pkg::NUM_ENT];
  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else o_v_r <= m_v_r;
    o_r <= res_nxt;
  end

  assign out_valid = o_v_r;
  assign out_tensor_xx = o_r[0];
  assign out_tensor_yy = o_r[1];
  assign out_tensor_zz = o_r[2];
  assign out_tensor_xy = o_r[3];
  assign out_tensor_xz = o_r[4];
  assign out_tensor_yz = o_r[5];

  a_noreset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
  a_chain: assert property (@(posedge clk) disable iff (!rst_n) a_v_r |=> m_v_r)
    else $error("valid lost in multiply stage");
  a_slow_off: assert property (@(posedge clk) disable iff (!rst_n)
      (m_v_r && !m_act_r) |=> (out_tensor_xy == 48'sd0 && out_tensor_yz == 48'sd0))
    else $error("slow flow gave off-diagonal term");
endmodule
